// ===== design/cms_pkg.sv =====
// Package: shared constants and types for the column mean / std-dev unit.
`default_nettype none
package cms_pkg;
  localparam int MAX_ROWS_DEF     = 1024;
  localparam int SAMPLE_WIDTH_DEF = 32;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [31:0] sample;
    logic        last_of_column;
  } in_word_t;

  typedef struct packed {
    logic [31:0] column_mean;
    logic [31:0] std_dev;
    logic [1:0]  status;
  } out_word_t;
endpackage
`default_nettype wire

// ===== design/cms_if.sv =====
// Interfaces: valid/ready channels for sample input and result output.
`default_nettype none
interface cms_in_if;
  logic               valid;
  logic               ready;
  cms_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cms_out_if;
  logic               valid;
  logic               ready;
  cms_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/cms_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module cms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== design/cms_math.sv =====
// Sequential math unit: signed 64/32 divide, 96/32 divide and 64-bit integer sqrt.
`default_nettype none
module cms_math (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start_div,   // sum / n
  input  wire logic        start_var,   // ss / (n-1), then sqrt
  input  wire logic [63:0] sum,
  input  wire logic [95:0] ss,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [63:0]      result
);
  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_DIV  = 3'd1;
  localparam logic [2:0] M_VDIV = 3'd2;
  localparam logic [2:0] M_SQRT = 3'd3;
  localparam logic [2:0] M_DONE = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [95:0] num_r, num_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] sv_r, sv_nxt, sres_r, sres_nxt;
  logic [63:0] sbit_r, sbit_nxt;
  logic [63:0] res_r, res_nxt;
  logic [32:0] trial;
  logic [63:0] stry;

  always_comb begin
    trial = {rem_r[31:0], num_r[95]} - {1'b0, divisor};
    stry  = sres_r + sbit_r;
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; num_nxt = num_r; rem_nxt = rem_r;
    neg_nxt = neg_r; sv_nxt = sv_r; sres_nxt = sres_r; sbit_nxt = sbit_r;
    res_nxt = res_r;
    unique case (st_r)
      M_IDLE: begin
        if (start_div) begin
          neg_nxt = sum[63];
          num_nxt = {(sum[63] ? -sum : sum), 32'd0};
          rem_nxt = '0; cnt_nxt = 7'd64; st_nxt = M_DIV;
        end else if (start_var) begin
          num_nxt = ss; rem_nxt = '0; cnt_nxt = 7'd96; st_nxt = M_VDIV;
        end
      end
      M_DIV, M_VDIV: begin
        if (!trial[32]) rem_nxt = trial;
        else rem_nxt = {rem_r[31:0], num_r[95]};
        num_nxt = {num_r[94:0], ~trial[32]};
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          if (st_r == M_DIV) begin
            res_nxt = neg_r ? -{num_r[62:0], ~trial[32]} : {num_r[62:0], ~trial[32]};
            st_nxt = M_DONE;
          end else if (num_r[94:63] != 32'd0) begin
            res_nxt = 64'hFFFF_FFFF; st_nxt = M_DONE;
          end else begin
            sv_nxt = {num_r[62:0], ~trial[32]};
            sres_nxt = '0; sbit_nxt = 64'h4000_0000_0000_0000;
            cnt_nxt = 7'd32; st_nxt = M_SQRT;
          end
        end
      end
      M_SQRT: begin
        if (sv_r >= stry) begin
          sv_nxt = sv_r - stry; sres_nxt = (sres_r >> 1) + sbit_r;
        end else sres_nxt = sres_r >> 1;
        sbit_nxt = sbit_r >> 2;
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          res_nxt = {32'd0, sres_nxt[31:0]}; st_nxt = M_DONE;
        end
      end
      M_DONE: st_nxt = M_IDLE;
      default: st_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= M_IDLE;
    else st_r <= st_nxt;
    cnt_r <= cnt_nxt; num_r <= num_nxt; rem_r <= rem_nxt; neg_r <= neg_nxt;
    sv_r <= sv_nxt; sres_r <= sres_nxt; sbit_r <= sbit_nxt; res_r <= res_nxt;
  end

  assign done   = (st_r == M_DONE);
  assign result = res_r;
endmodule
`default_nettype wire

// ===== design/column_mean_stddev_unit.sv =====
// Top level: two-pass column mean and sample standard deviation.
// Samples are written to a RAM at one word per cycle while loading, unless a
// result is still pending. On the word flagged last_of_column the block stops
// accepting and runs: a sum pass, a signed divide, a squared-residual pass,
// a divide by n-1 and a square root, then holds the result in an output
// register. The column rate is set by the single RAM port and the bit-serial
// math unit; error columns skip the passes and go straight to the output.
`default_nettype none
module column_mean_stddev_unit #(
  parameter int MAX_ROWS     = cms_pkg::MAX_ROWS_DEF,
  parameter int SAMPLE_WIDTH = cms_pkg::SAMPLE_WIDTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  cms_in_if.sink    in_ch,
  cms_out_if.source out_ch
);
  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_VAR  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]    st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          rv_r, rv_nxt;
  logic [63:0]   sum_r, sum_nxt;
  logic [31:0]   mean_r, mean_nxt;
  logic [95:0]   ss_r, ss_nxt;
  logic [32:0]   mag_r, mag_nxt;
  logic          mv_r, mv_nxt;
  logic          ov_r, ov_nxt;
  cms_pkg::out_word_t od_r, od_nxt;

  logic                    we;
  logic [AW-1:0]           addr;
  logic [SAMPLE_WIDTH-1:0] rdata;
  logic signed [63:0]      samp_ext, diff;
  logic                    acc, start_div, start_var, mdone;
  logic [63:0]             mres;
  logic [31:0]             divisor;

  cms_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_ROWS)) u_ram (
    .clk(clk), .we(we), .addr(addr),
    .wdata(in_ch.data.sample[SAMPLE_WIDTH-1:0]), .rdata(rdata));

  cms_math u_math (
    .clk(clk), .rst_n(rst_n), .start_div(start_div), .start_var(start_var),
    .sum(sum_r), .ss(ss_r), .divisor(divisor), .done(mdone), .result(mres));

  assign in_ch.ready = (st_r == S_LOAD) && !ov_r;
  assign acc = in_ch.valid && in_ch.ready;
  assign we  = acc && (cnt_r < CW'(MAX_ROWS));
  assign addr = (st_r == S_LOAD) ? cnt_r[AW-1:0] : idx_r[AW-1:0];
  assign samp_ext = 64'(signed'(rdata));
  assign diff = samp_ext - 64'(signed'(mean_r));
  assign start_div = (st_r == S_SUM) && !rv_r && (idx_r == cnt_r);
  assign start_var = (st_r == S_SQ) && !rv_r && !mv_r && (idx_r == cnt_r);
  assign divisor = (st_r == S_DIV) ? 32'(cnt_r) : 32'(cnt_r - CW'(1));

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r; idx_nxt = idx_r;
    rv_nxt = 1'b0; sum_nxt = sum_r; mean_nxt = mean_r; ss_nxt = ss_r;
    mag_nxt = mag_r; mv_nxt = 1'b0; ov_nxt = ov_r; od_nxt = od_r;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (st_r)
      S_LOAD: begin
        if (acc) begin
          if (cnt_r < CW'(MAX_ROWS)) cnt_nxt = cnt_r + CW'(1);
          else ovf_nxt = 1'b1;
          if (in_ch.data.last_of_column) begin
            if (ovf_r || cnt_r >= CW'(MAX_ROWS)) begin
              od_nxt = '{32'd0, 32'd0, cms_pkg::STATUS_OVERFLOW};
              st_nxt = S_OUT;
            end else if (cnt_r == CW'(0)) begin
              od_nxt = '{32'd0, 32'd0, cms_pkg::STATUS_SHORT};
              st_nxt = S_OUT;
            end else begin
              idx_nxt = '0; sum_nxt = '0; st_nxt = S_SUM;
            end
          end
        end
      end
      S_SUM: begin
        if (rv_r) sum_nxt = sum_r + samp_ext;
        if (idx_r != cnt_r) begin
          idx_nxt = idx_r + CW'(1); rv_nxt = 1'b1;
        end else if (!rv_r) st_nxt = S_DIV;
      end
      S_DIV: begin
        if (mdone) begin
          mean_nxt = mres[31:0]; idx_nxt = '0; ss_nxt = '0; st_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (rv_r) begin
          mag_nxt = diff[63] ? 33'(-diff) : 33'(diff);
          mv_nxt = 1'b1;
        end
        if (mv_r) ss_nxt = ss_r + 96'({31'd0, mag_r} * {31'd0, mag_r});
        if (idx_r != cnt_r) begin
          idx_nxt = idx_r + CW'(1); rv_nxt = 1'b1;
        end else if (!rv_r && !mv_r) st_nxt = S_VAR;
      end
      S_VAR: begin
        if (mdone) begin
          od_nxt = '{mean_r, mres[31:0], cms_pkg::STATUS_OK};
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        ov_nxt = 1'b1; cnt_nxt = '0; ovf_nxt = 1'b0; st_nxt = S_LOAD;
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0; ov_r <= 1'b0;
      rv_r <= 1'b0; mv_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; ov_r <= ov_nxt;
      rv_r <= rv_nxt; mv_r <= mv_nxt;
    end
    idx_r <= idx_nxt; sum_r <= sum_nxt; mean_r <= mean_nxt; ss_r <= ss_nxt;
    mag_r <= mag_nxt; od_r <= od_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;
endmodule
`default_nettype wire

// ===== design/cms_checker.sv =====
// Checker: port-level assertions on the column mean / std-dev unit.
`default_nettype none
module cms_checker (
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  in_valid,
  input wire logic  in_ready,
  input wire logic  in_last,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_mean,
  input wire logic [31:0] out_std
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != cms_pkg::STATUS_OK |-> out_mean == 32'd0 && out_std == 32'd0)
    else $error("error result with nonzero payload");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= cms_pkg::STATUS_OVERFLOW) else $error("bad status");
  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input accepted right after column close");
endmodule

bind column_mean_stddev_unit cms_checker u_cms_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_last(in_ch.data.last_of_column),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.data.status), .out_mean(out_ch.data.column_mean),
  .out_std(out_ch.data.std_dev));
`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench: column mean / std-dev unit checked against a behavioral predictor.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    logic [31:0]        sample;
    logic               last;
    bit                 typed;
    cms_pkg::out_word_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  cms_in_if  in_ch ();
  cms_out_if out_ch ();

  column_mean_stddev_unit DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  int                 col_words[$];
  bit                 col_ovf;
  cms_pkg::out_word_t result_q[$];
  int                 in_idle_pct = 0;
  int                 out_stall_pct = 0;
  int                 errors = 0;
  int                 quiet_cycles = 0;

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic cms_pkg::out_word_t close_column();
    cms_pkg::out_word_t o;
    longint       sum;
    longint       mean;
    longint       diff;
    logic [63:0]  mag;
    logic [127:0] ss;
    logic [127:0] q;
    logic [63:0]  root;
    int           n;
    o = '0;
    n = col_words.size();
    if (col_ovf) begin
      o.status = cms_pkg::STATUS_OVERFLOW;
    end else if (n < 2) begin
      o.status = cms_pkg::STATUS_SHORT;
    end else begin
      sum = 0;
      foreach (col_words[i]) sum += longint'(col_words[i]);
      mean = sum / longint'(n);
      ss = 0;
      foreach (col_words[i]) begin
        diff = longint'(col_words[i]) - mean;
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        ss += 128'(mag * mag);
      end
      q = ss / 128'(n - 1);
      root = floor_root(q[63:0]);
      o.column_mean = mean[31:0];
      o.std_dev = (q[127:64] != 0) ? 32'hFFFF_FFFF : root[31:0];
      o.status = cms_pkg::STATUS_OK;
    end
    col_words.delete();
    col_ovf = 1'b0;
    return o;
  endfunction

  // returns 1 if the word closed a column, prediction in res
  function automatic bit take_word(logic [31:0] s, logic last, output cms_pkg::out_word_t res);
    res = '0;
    if (col_words.size() < cms_pkg::MAX_ROWS_DEF) col_words.push_back(int'(s));
    else col_ovf = 1'b1;
    if (!last) return 0;
    res = close_column();
    return 1;
  endfunction

  task automatic send_word(logic [31:0] s, logic last, bit typed, cms_pkg::out_word_t tres);
    cms_pkg::out_word_t pres;
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{sample: s, last_of_column: last};
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (take_word(s, last, pres)) result_q.push_back(typed ? tres : pres);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_sample(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3) : 32'h8000_0000 + $urandom_range(3);
      default: return 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
    endcase
  endfunction

  task automatic send_column(int n, bit noise);
    int kind;
    kind = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      send_word(rand_sample(noise ? $urandom_range(3) : kind), i == n - 1, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        if (out_ch.data.column_mean !== result_q[0].column_mean) begin
          $error("column_mean exp %h got %h", result_q[0].column_mean, out_ch.data.column_mean);
          errors++;
        end
        if (out_ch.data.std_dev !== result_q[0].std_dev) begin
          $error("std_dev exp %h got %h", result_q[0].std_dev, out_ch.data.std_dev);
          errors++;
        end
        if (out_ch.data.status !== result_q[0].status) begin
          $error("status exp %0d got %0d", result_q[0].status, out_ch.data.status);
          errors++;
        end
        void'(result_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("column_mean_stddev_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  stim_row_t table_rows[] = '{
    '{32'h0001_0000, 1'b1, 1'b1, '{32'd0, 32'd0, cms_pkg::STATUS_SHORT}},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b1, 1'b1, '{32'd0, 32'd0, cms_pkg::STATUS_OK}},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b1, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 32'd0, cms_pkg::STATUS_OK}},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, '{32'h7FFF_FFFF, 32'd0, cms_pkg::STATUS_OK}},
    '{32'hFFFF_FFFD, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b1, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h0000_0001, 1'b0, 1'b0, '0},
    '{32'h0003_0000, 1'b1, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b1, 1'b0, '0},
    '{32'h5555_5555, 1'b1, 1'b1, '{32'd0, 32'd0, cms_pkg::STATUS_SHORT}}
  };

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    col_ovf = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (table_rows[i]) begin
      send_word(table_rows[i].sample, table_rows[i].last, table_rows[i].typed, table_rows[i].res);
    end
    for (int ph = 0; ph < 4; ph++) begin
      int sent;
      in_idle_pct   = (ph == 1) ? 53 : (ph == 3) ? 16 : 0;
      out_stall_pct = (ph == 2) ? 53 : (ph == 3) ? 16 : 0;
      sent = 0;
      while (sent < 250) begin
        int n;
        int pick;
        pick = $urandom_range(99);
        n = (pick < 6) ? 1 : (pick < 10) ? $urandom_range(60, 25) : $urandom_range(24, 2);
        send_column(n, pick >= 85);
        sent += n;
      end
    end
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("column_mean_stddev_unit regression: pass");
    end else begin
      $display("column_mean_stddev_unit regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
